@@ design/sample_histogram_binner_top_defines.svh @@
// Assertion macros for the histogram binner top level.
`ifndef SAMPLE_HISTOGRAM_BINNER_TOP_DEFINES_SVH
`define SAMPLE_HISTOGRAM_BINNER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SHB_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define SHB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SHB_ASSERT_IMPLIES(label, ante, cons, msg)

`define SHB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ design/shb_pkg.sv @@
// Types and constants of the histogram binner.
`timescale 1ns / 1ps

package shb_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int SEL_W      = 12;
   localparam int VAL_W      = 32;
   localparam int OP_W       = 2;
   localparam int WIDTH_W    = 31;
   localparam int COUNT_W    = 13;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_MIN  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BIN_WIDTH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BIN_COUNT = 2'd2;

   localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = 31'd65536;
   localparam logic [COUNT_W-1:0] BIN_COUNT_RESET = 13'd4096;

   localparam logic [VAL_W-1:0] VAL_MAX = '1;

endpackage

@@ design/shb_req_if.sv @@
// Request channel: operation, sample and bin select.
`timescale 1ns / 1ps

interface shb_req_if;
   logic                                valid;
   logic                                ready;
   logic [shb_pkg::OP_W-1:0]            op;
   logic signed [shb_pkg::SAMPLE_W-1:0] sample;
   logic [shb_pkg::SEL_W-1:0]           bin_select;

   modport source (output valid, output op, output sample, output bin_select, input ready);
   modport sink (input valid, input op, input sample, input bin_select, output ready);
endinterface

@@ design/shb_rsp_if.sv @@
// Response channel: bin index, range flag and bin count.
`timescale 1ns / 1ps

interface shb_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [shb_pkg::SEL_W-1:0]  bin_index;
   logic                       in_range;
   logic [shb_pkg::VAL_W-1:0]  bin_value;

   modport source (output valid, output bin_index, output in_range, output bin_value,
                   input ready);
   modport sink (input valid, input bin_index, input in_range, input bin_value,
                 output ready);
endinterface

@@ design/sample_histogram_binner_top.sv @@
// Top level of the uniform-bin histogram binner.
`timescale 1ns / 1ps
`include "sample_histogram_binner_top_defines.svh"

// Uniform-bin histogram over signed Q16.16 samples, one item at a time. An add that lands
// in a bin passes through the bin limit product, the range check, the restoring divider
// (one quotient bit per cycle), then a read and a write-back on the bin RAM. An add below
// the range leaves after the limit product, and one at or above the last bin after the
// range check. A read in range reads the bin RAM; a read out of range or the unused op code
// goes straight to the result. A clear zeroes all MAX_BINS bins, one bin zeroed per cycle.
// After reset the block runs a clearing pass over all MAX_BINS bins before it takes the
// first request; configuration writes are taken at any time. A finished result waits in
// the response register while the next request is taken; while that register is held the
// next result waits in the block and the input stalls.
module sample_histogram_binner_top #(
   parameter int MAX_BINS = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [shb_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [shb_pkg::CSR_DATA_W-1:0]       csr_wdata,
   shb_req_if.sink                              req_if,
   shb_rsp_if.source                            rsp_if
);

   localparam int AW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int NB_W  = $clog2(MAX_BINS + 1);
   localparam int LIM_W = NB_W + shb_pkg::WIDTH_W;
   localparam int DS_W  = shb_pkg::WIDTH_W + AW;
   localparam int SC_W  = (AW > 1) ? $clog2(AW) : 1;
   localparam int VW    = shb_pkg::VAL_W;
   localparam int SW    = shb_pkg::SEL_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LIMIT,
      S_CHECK,
      S_DIV,
      S_FETCH,
      S_UPDATE,
      S_CLEAR,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic signed [shb_pkg::SAMPLE_W-1:0] base_min_ff, base_min_in;
   logic [shb_pkg::WIDTH_W-1:0]         bin_width_ff, bin_width_in;
   logic [shb_pkg::COUNT_W-1:0]         bin_count_ff, bin_count_in;

   logic [shb_pkg::OP_W-1:0] op_ff, op_in;
   logic                     neg_ff, neg_in;
   logic [31:0]              rem_ff, rem_in;
   logic [shb_pkg::WIDTH_W-1:0] w_ff, w_in;
   logic [NB_W-1:0]          nb_ff, nb_in;
   logic [LIM_W-1:0]         lim_ff, lim_in;
   logic [DS_W-1:0]          dsr_ff, dsr_in;
   logic [AW-1:0]            q_ff, q_in;
   logic [SC_W-1:0]          step_ff, step_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic [AW-1:0]            clr_cnt_ff, clr_cnt_in;
   logic                     clr_boot_ff, clr_boot_in;

   logic [SW-1:0] res_idx_ff, res_idx_in;
   logic          res_hit_ff, res_hit_in;
   logic [VW-1:0] res_val_ff, res_val_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_idx_ff, rsp_idx_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic [VW-1:0] rsp_val_ff, rsp_val_in;

   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   logic [VW-1:0]   ram_wdata;
   logic            ram_re;
   logic [VW-1:0]   ram_rdata;

   logic [NB_W-1:0]       nb_cur;
   logic signed [32:0]    diff;
   logic                  div_ge;
   logic                  req_xfer;
   logic                  out_free;
   logic [VW-1:0]         inc_val;

   shb_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_BINS)
   ) u_bin_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   assign nb_cur = (32'(bin_count_ff) > 32'(MAX_BINS)) ? NB_W'(MAX_BINS) : NB_W'(bin_count_ff);
   assign diff = 33'(req_if.sample) - 33'(base_min_ff);
   assign div_ge = (DS_W'(rem_ff) >= dsr_ff);
   assign req_xfer = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign inc_val = (ram_rdata == shb_pkg::VAL_MAX) ? ram_rdata : ram_rdata + VW'(1);

   assign ram_re    = (state_ff == S_FETCH);
   assign ram_we    = (state_ff == S_CLEAR) || (state_ff == S_UPDATE && op_ff == shb_pkg::OP_ADD);
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_cnt_ff : addr_ff;
   assign ram_wdata = (state_ff == S_CLEAR) ? '0 : inc_val;

   assign req_if.ready     = (state_ff == S_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.bin_index = rsp_idx_ff;
   assign rsp_if.in_range  = rsp_hit_ff;
   assign rsp_if.bin_value = rsp_val_ff;

   always_comb begin
      state_in     = state_ff;
      base_min_in  = base_min_ff;
      bin_width_in = bin_width_ff;
      bin_count_in = bin_count_ff;
      op_in        = op_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      w_in         = w_ff;
      nb_in        = nb_ff;
      lim_in       = lim_ff;
      dsr_in       = dsr_ff;
      q_in         = q_ff;
      step_in      = step_ff;
      addr_in      = addr_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_boot_in  = clr_boot_ff;
      res_idx_in   = res_idx_ff;
      res_hit_in   = res_hit_ff;
      res_val_in   = res_val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_val_in   = rsp_val_ff;

      if (csr_we) begin
         case (csr_addr)
            shb_pkg::CSR_BASE_MIN:  base_min_in  = csr_wdata;
            shb_pkg::CSR_BIN_WIDTH: bin_width_in = csr_wdata[shb_pkg::WIDTH_W-1:0];
            shb_pkg::CSR_BIN_COUNT: bin_count_in = csr_wdata[shb_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in      = req_if.op;
               nb_in      = nb_cur;
               res_idx_in = '0;
               res_hit_in = 1'b0;
               res_val_in = '0;
               case (req_if.op)
                  shb_pkg::OP_ADD: begin
                     neg_in   = diff[32];
                     rem_in   = diff[31:0];
                     w_in     = (bin_width_ff == '0) ? shb_pkg::WIDTH_W'(1) : bin_width_ff;
                     state_in = S_LIMIT;
                  end
                  shb_pkg::OP_READ: begin
                     res_idx_in = req_if.bin_select;
                     if (32'(req_if.bin_select) < 32'(nb_cur)) begin
                        addr_in  = AW'(req_if.bin_select);
                        state_in = S_FETCH;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  shb_pkg::OP_CLEAR: begin
                     clr_cnt_in  = '0;
                     clr_boot_in = 1'b0;
                     state_in    = S_CLEAR;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_LIMIT: begin
            lim_in   = LIM_W'(nb_ff) * LIM_W'(w_ff);
            state_in = neg_ff ? S_OUT : S_CHECK;
         end
         S_CHECK: begin
            if (LIM_W'(rem_ff) >= lim_ff) begin
               state_in = S_OUT;
            end else begin
               dsr_in   = DS_W'(w_ff) << (AW - 1);
               q_in     = '0;
               step_in  = SC_W'(AW - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_ge) begin
               rem_in = rem_ff - dsr_ff[31:0];
            end
            q_in   = AW'({q_ff, div_ge});
            dsr_in = dsr_ff >> 1;
            if (step_ff == '0) begin
               addr_in  = AW'({q_ff, div_ge});
               state_in = S_FETCH;
            end else begin
               step_in = step_ff - SC_W'(1);
            end
         end
         S_FETCH: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            res_idx_in = SW'(addr_ff);
            res_hit_in = 1'b1;
            res_val_in = (op_ff == shb_pkg::OP_ADD) ? inc_val : ram_rdata;
            state_in   = S_OUT;
         end
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(MAX_BINS - 1)) begin
               state_in = clr_boot_ff ? S_IDLE : S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = res_idx_ff;
               rsp_hit_in   = res_hit_ff;
               rsp_val_in   = res_val_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_boot_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
         base_min_ff  <= '0;
         bin_width_ff <= shb_pkg::BIN_WIDTH_RESET;
         bin_count_ff <= shb_pkg::BIN_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_boot_ff  <= clr_boot_in;
         rsp_valid_ff <= rsp_valid_in;
         base_min_ff  <= base_min_in;
         bin_width_ff <= bin_width_in;
         bin_count_ff <= bin_count_in;
      end
      op_ff      <= op_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      w_ff       <= w_in;
      nb_ff      <= nb_in;
      lim_ff     <= lim_in;
      dsr_ff     <= dsr_in;
      q_ff       <= q_in;
      step_ff    <= step_in;
      addr_ff    <= addr_in;
      res_idx_ff <= res_idx_in;
      res_hit_ff <= res_hit_in;
      res_val_ff <= res_val_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_val_ff <= rsp_val_in;
   end

   `SHB_ASSERT_IMPLIES(a_ram_write_state, ram_we,
      (state_ff == S_CLEAR || state_ff == S_UPDATE), "bin RAM written outside clear or update")
   `SHB_ASSERT_IMPLIES(a_bin_in_range, (state_ff == S_FETCH && op_ff == shb_pkg::OP_ADD),
      (32'(addr_ff) < 32'(nb_ff)), "quotient beyond bins in use")
   `SHB_ASSERT_IMPLIES(a_add_hit_nonzero,
      (state_ff == S_OUT && res_hit_ff && op_ff == shb_pkg::OP_ADD),
      (res_val_ff != '0), "hit bin reports zero count")
   `SHB_ASSERT_IMPLIES(a_miss_zero, (state_ff == S_OUT && !res_hit_ff),
      (res_val_ff == '0), "missed item reports nonzero count")
   `SHB_ASSERT_NEXT(a_stall_hold, (rsp_valid_ff && !rsp_if.ready),
      (rsp_valid_ff && $stable(rsp_val_ff)), "stalled response changed")

endmodule

@@ design/shb_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module shb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
